/* src/gemm_micro_tile_12x4_top_assert.svh */
// ----------------------------------------------------------------------------
// gemm micro tile assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GEMM_MICRO_TILE_12X4_TOP_ASSERT_SVH
`define GEMM_MICRO_TILE_12X4_TOP_ASSERT_SVH

`ifndef SYNTH
`define GMT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gmt assertion failed");
`define GMT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmt assertion failed");
`define GMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmt assertion failed");
`else
`define GMT_ASSERT(lbl, prop)
`define GMT_ASSERT_IMPL(lbl, ante, cons)
`define GMT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/gmt_pkg.sv */
// ----------------------------------------------------------------------------
// gmt_pkg
// shared types and constants of the gemm micro tile
// ----------------------------------------------------------------------------
package gmt_pkg;

    localparam int TILE_COLS  = 4;
    localparam int GROUP_SIZE = 4;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int IDX_W      = 4;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_A   = 2'd1,
        OP_MAC      = 2'd2,
        OP_DRAIN    = 2'd3
    } opcode_t;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef word_t [TILE_COLS-1:0] row_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam prod_t ACC_MAX = (prod_t'(1) <<< (DATA_WIDTH - 1)) - prod_t'(1);
    localparam prod_t ACC_MIN = -ACC_MAX - prod_t'(1);

    // controller to datapath commands
    typedef struct packed {
        logic load_row;
        logic load_a;
        logic load_b;
        logic rd_en;
        logic mac_issue;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* src/gmt_item_if.sv */
// ----------------------------------------------------------------------------
// gmt_item_if
// input item channel: opcode, index and four fixed-point values
// ----------------------------------------------------------------------------
interface gmt_item_if;

    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [3:0]             index;
    logic signed [31:0]     value_0;
    logic signed [31:0]     value_1;
    logic signed [31:0]     value_2;
    logic signed [31:0]     value_3;

    modport source (
        output valid, opcode, index, value_0, value_1, value_2, value_3,
        input  ready
    );

    modport sink (
        input  valid, opcode, index, value_0, value_1, value_2, value_3,
        output ready
    );

endinterface

/* src/gmt_result_if.sv */
// ----------------------------------------------------------------------------
// gmt_result_if
// result channel: one tile row of four accumulators per transfer
// ----------------------------------------------------------------------------
interface gmt_result_if;

    logic                   valid;
    logic                   ready;
    logic [3:0]             row_number;
    logic signed [31:0]     out_0;
    logic signed [31:0]     out_1;
    logic signed [31:0]     out_2;
    logic signed [31:0]     out_3;
    logic                   last_row;

    modport source (
        output valid, row_number, out_0, out_1, out_2, out_3, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_number, out_0, out_1, out_2, out_3, last_row,
        output ready
    );

endinterface

/* src/gmt_controller.sv */
// ----------------------------------------------------------------------------
// gmt_controller
// sequences the row-serial multiply-accumulate and the tile drain
// ----------------------------------------------------------------------------
module gmt_controller #(
    parameter  int TILE_ROWS = 12,
    localparam int ROW_W     = $clog2(TILE_ROWS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic [gmt_pkg::OP_W-1:0] opcode,
    output logic                     item_ready,
    input  gmt_pkg::dp_stat_t        stat,
    output gmt_pkg::dp_cmd_t         cmd,
    output logic [ROW_W-1:0]         row_addr
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TILE_ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH_A,
        ST_FLUSH_B,
        ST_DRAIN_RD,
        ST_DRAIN_WAIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              accept;
    logic              at_last;
    gmt_pkg::opcode_t  op;

    assign op         = gmt_pkg::opcode_t'(opcode);
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign at_last    = (row_reg == LAST_ROW);
    assign row_addr   = row_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load_row  = accept && (op == gmt_pkg::OP_LOAD_ROW);
        cmd.load_a    = accept && (op == gmt_pkg::OP_LOAD_A);
        cmd.load_b    = accept && (op == gmt_pkg::OP_MAC);
        cmd.rd_en     = (state_reg == ST_MAC) || (state_reg == ST_DRAIN_RD);
        cmd.mac_issue = (state_reg == ST_MAC);
        cmd.out_load  = (state_reg == ST_DRAIN_WAIT) && stat.out_free;
        cmd.out_last  = at_last;
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                if (accept && (op == gmt_pkg::OP_MAC))
                begin
                    state_next = ST_MAC;
                end
                else if (accept && (op == gmt_pkg::OP_DRAIN))
                begin
                    state_next = ST_DRAIN_RD;
                end
            end
            ST_MAC:
            begin
                if (at_last)
                begin
                    state_next = ST_FLUSH_A;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_FLUSH_A:
            begin
                state_next = ST_FLUSH_B;
            end
            ST_FLUSH_B:
            begin
                state_next = ST_IDLE;
            end
            ST_DRAIN_RD:
            begin
                state_next = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT:
            begin
                if (stat.out_free)
                begin
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule

/* src/gmt_datapath.sv */
// ----------------------------------------------------------------------------
// gmt_datapath
// tile row memory, a column, four-lane multiply-accumulate pipe, output register
// ----------------------------------------------------------------------------
`include "gemm_micro_tile_12x4_top_assert.svh"

module gmt_datapath #(
    parameter  int TILE_ROWS = 12,
    localparam int ROW_W     = $clog2(TILE_ROWS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gmt_pkg::dp_cmd_t          cmd,
    input  logic [ROW_W-1:0]          row_addr,
    input  logic [gmt_pkg::IDX_W-1:0] in_index,
    input  gmt_pkg::row_t             in_values,
    output gmt_pkg::dp_stat_t         stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [gmt_pkg::IDX_W-1:0] out_row_number,
    output gmt_pkg::row_t             out_values,
    output logic                      out_last_row
);

    localparam int IDX_W      = gmt_pkg::IDX_W;
    localparam int GROUP_SIZE = gmt_pkg::GROUP_SIZE;
    localparam int TILE_COLS  = gmt_pkg::TILE_COLS;
    localparam int DATA_WIDTH = gmt_pkg::DATA_WIDTH;
    localparam int PROD_W     = gmt_pkg::PROD_W;

    // a column and b row operands
    gmt_pkg::word_t   a_col_reg [TILE_ROWS];
    gmt_pkg::row_t    b_reg;

    // tile memory, one row of four accumulators per entry
    gmt_pkg::row_t    tile_mem [TILE_ROWS];
    logic [TILE_ROWS-1:0] row_valid_reg;
    gmt_pkg::row_t    rd_data_reg;
    logic             rd_valid_reg;

    // pipe stage 1: read data and a operand
    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    gmt_pkg::word_t   a_s1_reg;
    gmt_pkg::row_t    acc_s1;
    gmt_pkg::prod_t   prod_s1 [TILE_COLS];

    // pipe stage 2: shifted products and old accumulators
    logic             s2_valid_reg;
    logic [ROW_W-1:0] s2_row_reg;
    gmt_pkg::prod_t   prod_s2_reg [TILE_COLS];
    gmt_pkg::row_t    acc_s2_reg;
    gmt_pkg::row_t    mac_row;

    // write port
    logic             row_in_range;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    gmt_pkg::row_t    wr_data;

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_row_reg;
    gmt_pkg::row_t    out_data_reg;
    logic             out_last_reg;

    assign row_in_range = ({1'b0, in_index} < (IDX_W + 1)'(TILE_ROWS));
    assign wr_en        = (cmd.load_row && row_in_range) || s2_valid_reg;
    assign wr_addr      = s2_valid_reg ? s2_row_reg : in_index[ROW_W-1:0];
    assign wr_data      = s2_valid_reg ? mac_row : in_values;
    assign acc_s1       = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int j = 0; j < TILE_COLS; j++)
        begin
            prod_s1[j] = (PROD_W'(a_s1_reg) * PROD_W'(b_reg[j])) >>> gmt_pkg::FRAC_BITS;
        end
    end

    // accumulate with saturation to the word range
    always_comb
    begin
        gmt_pkg::prod_t sum;
        for (int j = 0; j < TILE_COLS; j++)
        begin
            sum = prod_s2_reg[j] + PROD_W'(acc_s2_reg[j]);
            if (sum > gmt_pkg::ACC_MAX)
            begin
                mac_row[j] = gmt_pkg::ACC_MAX[DATA_WIDTH-1:0];
            end
            else if (sum < gmt_pkg::ACC_MIN)
            begin
                mac_row[j] = gmt_pkg::ACC_MIN[DATA_WIDTH-1:0];
            end
            else
            begin
                mac_row[j] = sum[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TILE_ROWS; i++)
            begin
                a_col_reg[i] <= '0;
            end
        end
        else if (cmd.load_a)
        begin
            for (int i = 0; i < TILE_ROWS; i++)
            begin
                if (in_index == IDX_W'(i / GROUP_SIZE))
                begin
                    a_col_reg[i] <= in_values[i % GROUP_SIZE];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
        begin
            b_reg <= in_values;
        end
        if (wr_en)
        begin
            tile_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= tile_mem[row_addr];
        end
        if (cmd.mac_issue)
        begin
            a_s1_reg   <= a_col_reg[row_addr];
            s1_row_reg <= row_addr;
        end
        s2_row_reg <= s1_row_reg;
        acc_s2_reg <= acc_s1;
        for (int j = 0; j < TILE_COLS; j++)
        begin
            prod_s2_reg[j] <= prod_s1[j];
        end
        if (cmd.out_load)
        begin
            out_row_reg  <= IDX_W'(row_addr);
            out_data_reg <= acc_s1;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[row_addr];
            end
            s1_valid_reg <= cmd.mac_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_row_number = out_row_reg;
    assign out_values     = out_data_reg;
    assign out_last_row   = out_last_reg;

    // a row load never collides with a pipe write-back
    `GMT_ASSERT(a_no_wr_clash, !(cmd.load_row && s2_valid_reg))
    // a drain row is only loaded into a free output register
    `GMT_ASSERT_IMPL(a_out_load_free, cmd.out_load, !out_valid_reg || out_ready)
    // every issued row reaches write-back with its own address
    `GMT_ASSERT_NEXT(a_pipe_order, s1_valid_reg, s2_valid_reg && (s2_row_reg == $past(s1_row_reg)))

endmodule

/* src/gemm_micro_tile_12x4_top.sv */
// ----------------------------------------------------------------------------
// gemm_micro_tile_12x4_top
// outer-product gemm micro tile with a q16.16 accumulator tile
// ----------------------------------------------------------------------------
// usage
//   item channel: opcode, index and four q16.16 values per transfer
//     load tile row   - one accumulator row, taken in the transfer cycle
//     load a group    - four a column entries, taken in the transfer cycle
//     mac b row       - rank-1 update a column x b row over the whole tile
//     drain           - streams the tile out row by row, tile kept as is
//   result channel: row number, four accumulators and a last row flag
// timing
//   loads do not hold the block; a mac item holds it while it steps
//   one tile row per cycle through the four-lane multiplier pipe
//   and the one-read one-write tile memory, then through the pipe flush states
//   a drain reads each row and loads it into the output register once that
//   register is free, then steps on to the next row until the last one
// reset
//   the tile and the a column read as zero after reset (row valid bits)
// back-pressure
//   a stalled result channel holds the output register and the drain
//   waits; the next item is taken once the last row sits in the register
// ----------------------------------------------------------------------------
module gemm_micro_tile_12x4_top #(
    parameter int TILE_ROWS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    gmt_item_if.sink           item,
    gmt_result_if.source       result
);

    localparam int ROW_W = $clog2(TILE_ROWS);

    gmt_pkg::dp_cmd_t   cmd;
    gmt_pkg::dp_stat_t  stat;
    logic [ROW_W-1:0]   row_addr;
    logic               item_ready;
    gmt_pkg::row_t      in_values;
    gmt_pkg::row_t      out_values;

    // gather the four item values into one row
    assign in_values  = {item.value_3, item.value_2, item.value_1, item.value_0};
    assign item.ready = item_ready;

    // sequencer: accepts items when idle and steps through tile rows
    gmt_controller #(
        .TILE_ROWS (TILE_ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .opcode     (item.opcode),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd),
        .row_addr   (row_addr)
    );

    // storage, multiply-accumulate pipe and result register
    gmt_datapath #(
        .TILE_ROWS (TILE_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .row_addr       (row_addr),
        .in_index       (item.index),
        .in_values      (in_values),
        .stat           (stat),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_row_number (result.row_number),
        .out_values     (out_values),
        .out_last_row   (result.last_row)
    );

    // spread the row back over the result fields
    assign result.out_0 = out_values[0];
    assign result.out_1 = out_values[1];
    assign result.out_2 = out_values[2];
    assign result.out_3 = out_values[3];

endmodule
